// ----- sv/two_wire_debug_frame_engine_defines.svh -----
// Assertion macros for the two-wire debug frame engine.
`ifndef TWO_WIRE_DEBUG_FRAME_ENGINE_DEFINES_SVH
`define TWO_WIRE_DEBUG_FRAME_ENGINE_DEFINES_SVH
`ifndef SYNTH
`define TWDF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("twdf assertion failed");
`define TWDF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("twdf assertion failed");
`else
`define TWDF_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define TWDF_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- sv/twdf_pkg.sv -----
// Types and constants shared by the two-wire debug frame engine.
`timescale 1ns / 1ps
package twdf_pkg;
	localparam int BYTE_W = 8;

	typedef enum logic [1:0] {
		KIND_TICK = 2'd0,
		KIND_SEND = 2'd1,
		KIND_READ = 2'd2,
		KIND_IDLE = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		MODE_NONE = 2'd0,
		MODE_SEND = 2'd1,
		MODE_READ = 2'd2,
		MODE_IDLE = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		PH_START_CLK_LO = 3'd0,
		PH_START_DAT_LO = 3'd1,
		PH_START_CLK_HI = 3'd2,
		PH_BIT_CLK_LO   = 3'd3,
		PH_BIT_CLK_HI   = 3'd4,
		PH_STOP_CLK_LO  = 3'd5,
		PH_STOP_CLK_HI  = 3'd6
	} phase_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic              start_bit;
		logic [BYTE_W-1:0] data_byte;
		logic              stop_value;
		logic [BYTE_W-1:0] idle_count;
		logic              dat_pin;
	} cmd_t;

	typedef struct packed {
		logic              clk_out;
		logic              dat_out;
		logic              dat_drive;
		logic              busy_res;
		logic              done_res;
		logic [BYTE_W-1:0] read_byte;
	} res_t;
endpackage

// ----- sv/twdf_ifs.sv -----
// Valid/ready channel interfaces for commands and pin results.
`timescale 1ns / 1ps
interface twdf_cmd_if;
	logic                         valid;
	logic                         ready;
	logic [1:0]                   kind;
	logic                         start_bit;
	logic [twdf_pkg::BYTE_W-1:0]  data_byte;
	logic                         stop_value;
	logic [twdf_pkg::BYTE_W-1:0]  idle_count;
	logic                         dat_pin;

	modport source(output valid, kind, start_bit, data_byte, stop_value, idle_count,
		dat_pin, input ready);
	modport sink(input valid, kind, start_bit, data_byte, stop_value, idle_count,
		dat_pin, output ready);
endinterface

interface twdf_res_if;
	logic                         valid;
	logic                         ready;
	logic                         clk_out;
	logic                         dat_out;
	logic                         dat_drive;
	logic                         busy_res;
	logic                         done_res;
	logic [twdf_pkg::BYTE_W-1:0]  read_byte;

	modport source(output valid, clk_out, dat_out, dat_drive, busy_res, done_res,
		read_byte, input ready);
	modport sink(input valid, clk_out, dat_out, dat_drive, busy_res, done_res,
		read_byte, output ready);
endinterface

// ----- sv/twdf_core.sv -----
// Frame state machine: state registers and one-phase-per-item next-state logic.
`timescale 1ns / 1ps
`include "two_wire_debug_frame_engine_defines.svh"
module twdf_core #(
	parameter int DATA_BITS = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            fire,
	input  twdf_pkg::cmd_t  cmd,
	output twdf_pkg::res_t  res
);
	localparam int BIT_W = $clog2(DATA_BITS + 1);
	localparam int BW    = twdf_pkg::BYTE_W;

	twdf_pkg::mode_t  mode_q, mode_d;
	twdf_pkg::phase_t phase_q, phase_d;
	logic [BIT_W-1:0] bit_q, bit_d;
	logic [BIT_W:0]   bit_inc;
	logic [BW-1:0]    shift_q, shift_d;
	logic [BW-1:0]    idle_q, idle_d, idle_dec;
	logic             start_q, start_d;
	logic             stop_q, stop_d;
	logic             clk_q, clk_n, clk_d;
	logic             dat_q, dat_d;
	logic             drv_q, drv_d;
	logic [BW-1:0]    last_q, last_d;
	logic             done;

	assign bit_inc  = {1'b0, bit_q} + (BIT_W + 1)'(1);
	assign idle_dec = idle_q - BW'(1);

	// next state
	always_comb begin
		mode_d  = mode_q;
		phase_d = phase_q;
		bit_d   = bit_q;
		shift_d = shift_q;
		idle_d  = idle_q;
		start_d = start_q;
		stop_d  = stop_q;
		clk_n   = clk_q;
		dat_d   = dat_q;
		drv_d   = drv_q;
		last_d  = last_q;
		done    = 1'b0;
		if (cmd.kind == twdf_pkg::KIND_TICK) begin
			if (mode_q != twdf_pkg::MODE_NONE) begin
				case (phase_q)
					twdf_pkg::PH_START_CLK_LO: begin
						clk_n   = 1'b0;
						phase_d = twdf_pkg::PH_START_DAT_LO;
					end
					twdf_pkg::PH_START_DAT_LO: begin
						dat_d   = 1'b0;
						phase_d = twdf_pkg::PH_START_CLK_HI;
					end
					twdf_pkg::PH_START_CLK_HI: begin
						clk_n   = 1'b1;
						bit_d   = '0;
						phase_d = twdf_pkg::PH_BIT_CLK_LO;
					end
					twdf_pkg::PH_BIT_CLK_LO: begin
						clk_n = 1'b0;
						if (mode_q == twdf_pkg::MODE_SEND)
							dat_d = shift_q[0];
						else if (mode_q == twdf_pkg::MODE_READ)
							drv_d = 1'b0;
						phase_d = twdf_pkg::PH_BIT_CLK_HI;
					end
					twdf_pkg::PH_BIT_CLK_HI: begin
						clk_n = 1'b1;
						if (mode_q == twdf_pkg::MODE_IDLE) begin
							idle_d = idle_dec;
							if (idle_dec == '0) begin
								mode_d  = twdf_pkg::MODE_NONE;
								phase_d = twdf_pkg::PH_START_CLK_LO;
								done    = 1'b1;
							end else begin
								phase_d = twdf_pkg::PH_BIT_CLK_LO;
							end
						end else begin
							if (mode_q == twdf_pkg::MODE_SEND)
								shift_d = {1'b0, shift_q[BW-1:1]};
							else
								shift_d = {cmd.dat_pin, shift_q[BW-1:1]};
							bit_d   = bit_inc[BIT_W-1:0];
							phase_d = (bit_inc >= (BIT_W + 1)'(DATA_BITS)) ?
								twdf_pkg::PH_STOP_CLK_LO : twdf_pkg::PH_BIT_CLK_LO;
						end
					end
					twdf_pkg::PH_STOP_CLK_LO: begin
						clk_n = 1'b0;
						drv_d = 1'b1;
						dat_d = stop_q;
						if (mode_q == twdf_pkg::MODE_READ) begin
							last_d  = shift_q;
							mode_d  = twdf_pkg::MODE_NONE;
							phase_d = twdf_pkg::PH_START_CLK_LO;
							done    = 1'b1;
						end else begin
							phase_d = twdf_pkg::PH_STOP_CLK_HI;
						end
					end
					default: begin
						clk_n   = 1'b1;
						mode_d  = twdf_pkg::MODE_NONE;
						phase_d = twdf_pkg::PH_START_CLK_LO;
						done    = 1'b1;
					end
				endcase
			end
		end else if (mode_q == twdf_pkg::MODE_NONE) begin
			if (cmd.kind == twdf_pkg::KIND_IDLE) begin
				dat_d = 1'b1;
				if (cmd.idle_count == '0) begin
					done = 1'b1;
				end else begin
					idle_d  = cmd.idle_count;
					mode_d  = twdf_pkg::MODE_IDLE;
					phase_d = twdf_pkg::PH_BIT_CLK_LO;
				end
			end else begin
				mode_d  = twdf_pkg::mode_t'(cmd.kind);
				start_d = cmd.start_bit;
				stop_d  = cmd.stop_value;
				shift_d = (cmd.kind == twdf_pkg::KIND_SEND) ? cmd.data_byte : '0;
				bit_d   = '0;
				phase_d = cmd.start_bit ? twdf_pkg::PH_START_CLK_LO
					: twdf_pkg::PH_BIT_CLK_LO;
			end
		end
		// read stop raises the clock after its last period
		clk_d = clk_n;
		if (cmd.kind == twdf_pkg::KIND_TICK && done && dat_d == stop_d && drv_d && !clk_n)
			clk_d = 1'b1;
	end

	// result
	always_comb begin
		res.clk_out   = clk_n;
		res.dat_out   = dat_d;
		res.dat_drive = drv_d;
		res.busy_res  = (mode_d != twdf_pkg::MODE_NONE);
		res.done_res  = done;
		res.read_byte = last_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= twdf_pkg::MODE_NONE;
			phase_q <= twdf_pkg::PH_START_CLK_LO;
			bit_q   <= '0;
			shift_q <= '0;
			idle_q  <= '0;
			start_q <= 1'b0;
			stop_q  <= 1'b0;
			clk_q   <= 1'b0;
			dat_q   <= 1'b0;
			drv_q   <= 1'b1;
			last_q  <= '0;
		end else if (fire) begin
			mode_q  <= mode_d;
			phase_q <= phase_d;
			bit_q   <= bit_d;
			shift_q <= shift_d;
			idle_q  <= idle_d;
			start_q <= start_d;
			stop_q  <= stop_d;
			clk_q   <= clk_d;
			dat_q   <= dat_d;
			drv_q   <= drv_d;
			last_q  <= last_d;
		end
	end

	`TWDF_ASSERT_IMP(a_idle_phase, clk, arst_n, mode_q == twdf_pkg::MODE_NONE, phase_q == twdf_pkg::PH_START_CLK_LO)
	`TWDF_ASSERT_IMP(a_release_read, clk, arst_n, !drv_q, mode_q == twdf_pkg::MODE_READ)
	`TWDF_ASSERT_NXT(a_done_ends, clk, arst_n, fire && done && cmd.kind == twdf_pkg::KIND_TICK, mode_q == twdf_pkg::MODE_NONE)
	`TWDF_ASSERT_IMP(a_bit_range, clk, arst_n, 1'b1, {1'b0, bit_q} <= (BIT_W + 1)'(DATA_BITS))
endmodule

// ----- sv/two_wire_debug_frame_engine.sv -----
// Top level of the two-wire debug frame engine: input stage, frame core, result stage.
// A result reaches res through the input stage and result stage registers.
// Throughput: one command or tick per cycle while the result is not stalled.
// Input and result stages form a two-deep pipeline; a stalled result freezes the core,
// and an empty input stage still takes one transfer. Reset (arst_n low, asynchronous):
// no frame, clock and data low, data driven, last read byte zero, both stages empty.
`timescale 1ns / 1ps
module two_wire_debug_frame_engine #(
	parameter int DATA_BITS = 8
) (
	input logic            clk,
	input logic            arst_n,
	twdf_cmd_if.sink       cmd,
	twdf_res_if.source     res
);
	twdf_pkg::cmd_t cmd_s1;
	logic           valid_s1;
	twdf_pkg::res_t res_c;
	twdf_pkg::res_t res_s2;
	logic           valid_s2;
	logic           advance;
	logic           fire;

	assign advance   = !valid_s2 || res.ready;
	assign fire      = valid_s1 && advance;
	assign cmd.ready = advance || !valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			cmd_s1.kind       <= cmd.kind;
			cmd_s1.start_bit  <= cmd.start_bit;
			cmd_s1.data_byte  <= cmd.data_byte;
			cmd_s1.stop_value <= cmd.stop_value;
			cmd_s1.idle_count <= cmd.idle_count;
			cmd_s1.dat_pin    <= cmd.dat_pin;
		end
	end

	twdf_core #(
		.DATA_BITS(DATA_BITS)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.fire  (fire),
		.cmd   (cmd_s1),
		.res   (res_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res_c;
		end
	end

	assign res.valid     = valid_s2;
	assign res.clk_out   = res_s2.clk_out;
	assign res.dat_out   = res_s2.dat_out;
	assign res.dat_drive = res_s2.dat_drive;
	assign res.busy_res  = res_s2.busy_res;
	assign res.done_res  = res_s2.done_res;
	assign res.read_byte = res_s2.read_byte;
endmodule

// ----- tb/two_wire_debug_frame_engine_tb.sv -----
// Self-checking testbench for the two-wire debug frame engine: directed table, then random frames.
`timescale 1ns / 1ps
module two_wire_debug_frame_engine_tb;
	localparam int FRAME_BITS  = 8;
	localparam int RAND_ITEMS  = 880;
	localparam int CYCLE_LIMIT = 400000;
	localparam int TAIL_CYCLES = 10;

	typedef struct {
		logic           has;
		twdf_pkg::res_t val;
	} pinned_t;

	typedef struct {
		twdf_pkg::cmd_t c;
		int unsigned    reps;
		logic           has;
		twdf_pkg::res_t val;
	} row_t;

	logic clk;
	logic arst_n;

	twdf_cmd_if cmd_if();
	twdf_res_if res_if();

	two_wire_debug_frame_engine #(.DATA_BITS(FRAME_BITS)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_if),
		.res(res_if)
	);

	// line state as the engine should hold it
	twdf_pkg::mode_t  line_mode;
	twdf_pkg::phase_t line_phase;
	logic [4:0] bit_cnt;
	logic [7:0] shreg;
	logic [7:0] idle_rem;
	logic       stop_lvl;
	logic       clk_lvl;
	logic       dat_lvl;
	logic       drv_en;
	logic [7:0] rd_byte;

	twdf_pkg::res_t pins_q[$];
	pinned_t        pin_q[$];
	row_t           rows[$];

	int src_idle_pct;
	int rcv_idle_pct;
	int cycle_cnt;
	int mism_cnt;
	int checked_cnt;
	int item_cnt;
	int send_frames;
	int read_frames;
	int idle_frames;

	twdf_pkg::cmd_t seen_cmd;
	twdf_pkg::res_t got_pins;
	twdf_pkg::res_t want_pins;
	pinned_t        seen_pin;

	localparam twdf_pkg::res_t NO_PINS = '0;

	function automatic twdf_pkg::res_t next_pins(input twdf_pkg::cmd_t c);
		twdf_pkg::res_t r;
		logic fin;
		logic clk_seen;
		fin = 1'b0;
		if (c.kind == twdf_pkg::KIND_TICK) begin
			if (line_mode != twdf_pkg::MODE_NONE) begin
				case (line_phase)
					twdf_pkg::PH_START_CLK_LO: begin
						clk_lvl = 1'b0;
						line_phase = twdf_pkg::PH_START_DAT_LO;
					end
					twdf_pkg::PH_START_DAT_LO: begin
						dat_lvl = 1'b0;
						line_phase = twdf_pkg::PH_START_CLK_HI;
					end
					twdf_pkg::PH_START_CLK_HI: begin
						clk_lvl = 1'b1;
						bit_cnt = '0;
						line_phase = twdf_pkg::PH_BIT_CLK_LO;
					end
					twdf_pkg::PH_BIT_CLK_LO: begin
						clk_lvl = 1'b0;
						if (line_mode == twdf_pkg::MODE_SEND)
							dat_lvl = shreg[0];
						else if (line_mode == twdf_pkg::MODE_READ)
							drv_en = 1'b0;
						line_phase = twdf_pkg::PH_BIT_CLK_HI;
					end
					twdf_pkg::PH_BIT_CLK_HI: begin
						clk_lvl = 1'b1;
						if (line_mode == twdf_pkg::MODE_IDLE) begin
							idle_rem = idle_rem - 8'd1;
							if (idle_rem == 8'd0) begin
								line_mode = twdf_pkg::MODE_NONE;
								line_phase = twdf_pkg::PH_START_CLK_LO;
								fin = 1'b1;
							end else begin
								line_phase = twdf_pkg::PH_BIT_CLK_LO;
							end
						end else begin
							if (line_mode == twdf_pkg::MODE_SEND)
								shreg = shreg >> 1;
							else
								shreg = {c.dat_pin, shreg[7:1]};
							bit_cnt = bit_cnt + 5'd1;
							line_phase = (bit_cnt >= FRAME_BITS) ?
								twdf_pkg::PH_STOP_CLK_LO : twdf_pkg::PH_BIT_CLK_LO;
						end
					end
					twdf_pkg::PH_STOP_CLK_LO: begin
						clk_lvl = 1'b0;
						drv_en = 1'b1;
						dat_lvl = stop_lvl;
						if (line_mode == twdf_pkg::MODE_READ) begin
							rd_byte = shreg;
							line_mode = twdf_pkg::MODE_NONE;
							line_phase = twdf_pkg::PH_START_CLK_LO;
							fin = 1'b1;
						end else begin
							line_phase = twdf_pkg::PH_STOP_CLK_HI;
						end
					end
					default: begin
						clk_lvl = 1'b1;
						line_mode = twdf_pkg::MODE_NONE;
						line_phase = twdf_pkg::PH_START_CLK_LO;
						fin = 1'b1;
					end
				endcase
			end
		end else if (line_mode == twdf_pkg::MODE_NONE) begin
			if (c.kind == twdf_pkg::KIND_IDLE) begin
				dat_lvl = 1'b1;
				if (c.idle_count == 8'd0) begin
					fin = 1'b1;
				end else begin
					idle_rem = c.idle_count;
					line_mode = twdf_pkg::MODE_IDLE;
					line_phase = twdf_pkg::PH_BIT_CLK_LO;
				end
				idle_frames++;
			end else begin
				line_mode = twdf_pkg::mode_t'(c.kind);
				stop_lvl = c.stop_value;
				shreg = (c.kind == twdf_pkg::KIND_SEND) ? c.data_byte : 8'h00;
				bit_cnt = '0;
				line_phase = c.start_bit ? twdf_pkg::PH_START_CLK_LO : twdf_pkg::PH_BIT_CLK_LO;
				if (c.kind == twdf_pkg::KIND_SEND)
					send_frames++;
				else
					read_frames++;
			end
		end
		clk_seen = clk_lvl;
		// read stop: clock rises with no further period
		if (c.kind == twdf_pkg::KIND_TICK && fin && dat_lvl == stop_lvl && drv_en && !clk_lvl)
			clk_lvl = 1'b1;
		r.clk_out = clk_seen;
		r.dat_out = dat_lvl;
		r.dat_drive = drv_en;
		r.busy_res = (line_mode != twdf_pkg::MODE_NONE);
		r.done_res = fin;
		r.read_byte = rd_byte;
		return r;
	endfunction

	function automatic twdf_pkg::cmd_t make_cmd(input twdf_pkg::kind_t k, input logic st,
		input logic [7:0] d, input logic sp, input logic [7:0] n, input logic pin);
		twdf_pkg::cmd_t c;
		c.kind = k;
		c.start_bit = st;
		c.data_byte = d;
		c.stop_value = sp;
		c.idle_count = n;
		c.dat_pin = pin;
		return c;
	endfunction

	function automatic twdf_pkg::cmd_t rand_cmd(input twdf_pkg::kind_t k);
		return make_cmd(k, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
			1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
	endfunction

	task automatic add_row(input twdf_pkg::cmd_t c, input int unsigned reps, input logic has,
		input twdf_pkg::res_t val);
		row_t r;
		r.c = c;
		r.reps = reps;
		r.has = has;
		r.val = val;
		rows.push_back(r);
	endtask

	task automatic drive_cmd(input twdf_pkg::cmd_t c, input logic has,
		input twdf_pkg::res_t val);
		pinned_t p;
		p.has = has;
		p.val = val;
		while ($urandom_range(0, 99) < src_idle_pct) begin
			cmd_if.valid <= 1'b0;
			@(posedge clk);
		end
		pin_q.push_back(p);
		cmd_if.valid <= 1'b1;
		cmd_if.kind <= c.kind;
		cmd_if.start_bit <= c.start_bit;
		cmd_if.data_byte <= c.data_byte;
		cmd_if.stop_value <= c.stop_value;
		cmd_if.idle_count <= c.idle_count;
		cmd_if.dat_pin <= c.dat_pin;
		do @(negedge clk); while (!cmd_if.ready);
		@(posedge clk);
	endtask

	task automatic drive_tick();
		drive_cmd(rand_cmd(twdf_pkg::KIND_TICK), 1'b0, NO_PINS);
	endtask

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		res_if.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
				pins_q.size());
			$display("FAILED: results differ");
			$finish;
		end
	end

	// transfers are sampled at the falling edge, away from any drive at the rising edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (cmd_if.valid && cmd_if.ready) begin
				seen_cmd.kind = cmd_if.kind;
				seen_cmd.start_bit = cmd_if.start_bit;
				seen_cmd.data_byte = cmd_if.data_byte;
				seen_cmd.stop_value = cmd_if.stop_value;
				seen_cmd.idle_count = cmd_if.idle_count;
				seen_cmd.dat_pin = cmd_if.dat_pin;
				seen_pin = pin_q.pop_front();
				want_pins = next_pins(seen_cmd);
				pins_q.push_back(seen_pin.has ? seen_pin.val : want_pins);
			end
			if (res_if.valid && res_if.ready) begin
				got_pins.clk_out = res_if.clk_out;
				got_pins.dat_out = res_if.dat_out;
				got_pins.dat_drive = res_if.dat_drive;
				got_pins.busy_res = res_if.busy_res;
				got_pins.done_res = res_if.done_res;
				got_pins.read_byte = res_if.read_byte;
				if (pins_q.size() == 0) begin
					mism_cnt++;
					if (mism_cnt <= 10)
						$display("unexpected result: clk=%b dat=%b drv=%b busy=%b done=%b rd=%h",
							got_pins.clk_out, got_pins.dat_out, got_pins.dat_drive,
							got_pins.busy_res, got_pins.done_res, got_pins.read_byte);
				end else begin
					want_pins = pins_q.pop_front();
					checked_cnt++;
					if (got_pins !== want_pins) begin
						mism_cnt++;
						if (mism_cnt <= 10) begin
							$display("result %0d expected clk=%b dat=%b drv=%b busy=%b done=%b rd=%h",
								checked_cnt, want_pins.clk_out, want_pins.dat_out,
								want_pins.dat_drive, want_pins.busy_res, want_pins.done_res,
								want_pins.read_byte);
							$display("result %0d got      clk=%b dat=%b drv=%b busy=%b done=%b rd=%h",
								checked_cnt, got_pins.clk_out, got_pins.dat_out,
								got_pins.dat_drive, got_pins.busy_res, got_pins.done_res,
								got_pins.read_byte);
						end
					end
				end
			end
		end
	end

	initial begin
		int unsigned frame_no;
		int unsigned len;
		int unsigned pick;
		twdf_pkg::cmd_t c;
		clk = 1'b0;
		arst_n = 1'b0;
		cycle_cnt = 0;
		mism_cnt = 0;
		checked_cnt = 0;
		item_cnt = 0;
		send_frames = 0;
		read_frames = 0;
		idle_frames = 0;
		src_idle_pct = 21;
		rcv_idle_pct = 47;
		cmd_if.valid = 1'b0;
		cmd_if.kind = twdf_pkg::KIND_TICK;
		cmd_if.start_bit = 1'b0;
		cmd_if.data_byte = '0;
		cmd_if.stop_value = 1'b0;
		cmd_if.idle_count = '0;
		cmd_if.dat_pin = 1'b0;
		res_if.ready = 1'b0;
		line_mode = twdf_pkg::MODE_NONE;
		line_phase = twdf_pkg::PH_START_CLK_LO;
		bit_cnt = '0;
		shreg = '0;
		idle_rem = '0;
		stop_lvl = 1'b0;
		clk_lvl = 1'b0;
		dat_lvl = 1'b0;
		drv_en = 1'b1;
		rd_byte = '0;

		// tick after reset, zero-count idle, tick with no frame
		add_row(make_cmd(twdf_pkg::KIND_TICK, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0), 1, 1'b1,
			{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00});
		add_row(make_cmd(twdf_pkg::KIND_IDLE, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0), 1, 1'b1,
			{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 8'h00});
		add_row(make_cmd(twdf_pkg::KIND_TICK, 1'b1, 8'hFF, 1'b1, 8'hFF, 1'b1), 1, 1'b1,
			{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00});
		// send with start bit, commands ignored while busy
		add_row(make_cmd(twdf_pkg::KIND_SEND, 1'b1, 8'hA5, 1'b1, 8'h00, 1'b0), 1, 1'b0,
			NO_PINS);
		add_row(make_cmd(twdf_pkg::KIND_SEND, 1'b1, 8'hFF, 1'b1, 8'hFF, 1'b1), 1, 1'b0,
			NO_PINS);
		add_row(make_cmd(twdf_pkg::KIND_IDLE, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0), 1, 1'b0,
			NO_PINS);
		add_row(make_cmd(twdf_pkg::KIND_TICK, 1'b0, 8'h00, 1'b0, 8'h00, 1'b1), 21, 1'b0,
			NO_PINS);
		// read without start, all ones; tick after read stop shows clock high
		add_row(make_cmd(twdf_pkg::KIND_READ, 1'b0, 8'hFF, 1'b0, 8'h00, 1'b0), 1, 1'b0,
			NO_PINS);
		add_row(make_cmd(twdf_pkg::KIND_TICK, 1'b0, 8'h00, 1'b0, 8'h00, 1'b1), 17, 1'b0,
			NO_PINS);
		add_row(make_cmd(twdf_pkg::KIND_TICK, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0), 1, 1'b0,
			NO_PINS);
		// read with start, all zeros
		add_row(make_cmd(twdf_pkg::KIND_READ, 1'b1, 8'h00, 1'b1, 8'h00, 1'b1), 1, 1'b0,
			NO_PINS);
		add_row(make_cmd(twdf_pkg::KIND_IDLE, 1'b1, 8'hFF, 1'b1, 8'h05, 1'b1), 1, 1'b0,
			NO_PINS);
		add_row(make_cmd(twdf_pkg::KIND_TICK, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0), 20, 1'b0,
			NO_PINS);
		// send extremes without start bit
		add_row(make_cmd(twdf_pkg::KIND_SEND, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0), 1, 1'b0,
			NO_PINS);
		add_row(make_cmd(twdf_pkg::KIND_TICK, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0), 18, 1'b0,
			NO_PINS);
		add_row(make_cmd(twdf_pkg::KIND_SEND, 1'b0, 8'hFF, 1'b1, 8'h00, 1'b0), 1, 1'b0,
			NO_PINS);
		add_row(make_cmd(twdf_pkg::KIND_TICK, 1'b0, 8'h00, 1'b0, 8'h00, 1'b1), 18, 1'b0,
			NO_PINS);
		// idle frames of one and three periods
		add_row(make_cmd(twdf_pkg::KIND_IDLE, 1'b0, 8'h00, 1'b0, 8'h01, 1'b0), 1, 1'b0,
			NO_PINS);
		add_row(make_cmd(twdf_pkg::KIND_TICK, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0), 2, 1'b0,
			NO_PINS);
		add_row(make_cmd(twdf_pkg::KIND_IDLE, 1'b0, 8'h00, 1'b0, 8'h03, 1'b0), 1, 1'b0,
			NO_PINS);
		add_row(make_cmd(twdf_pkg::KIND_TICK, 1'b0, 8'h00, 1'b0, 8'h00, 1'b1), 6, 1'b0,
			NO_PINS);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i])
			repeat (rows[i].reps)
				drive_cmd(rows[i].c, rows[i].has, rows[i].val);

		frame_no = 0;
		while (item_cnt < RAND_ITEMS) begin
			if (item_cnt < RAND_ITEMS / 3) begin
				src_idle_pct = 21;
				rcv_idle_pct = 47;
			end else if (item_cnt < 2 * RAND_ITEMS / 3) begin
				src_idle_pct = 47;
				rcv_idle_pct = 21;
			end else begin
				src_idle_pct = 0;
				rcv_idle_pct = 0;
			end
			// stray ticks with no frame
			if ($urandom_range(0, 5) == 0)
				repeat ($urandom_range(1, 3)) drive_tick();
			pick = $urandom_range(0, 9);
			if (pick < 4) begin
				c = rand_cmd(twdf_pkg::KIND_SEND);
				len = (c.start_bit ? 3 : 0) + 2 * FRAME_BITS + 2;
			end else if (pick < 8) begin
				c = rand_cmd(twdf_pkg::KIND_READ);
				len = (c.start_bit ? 3 : 0) + 2 * FRAME_BITS + 1;
			end else begin
				c = rand_cmd(twdf_pkg::KIND_IDLE);
				c.idle_count = (frame_no == 12) ? 8'hFF : 8'($urandom_range(0, 12));
				len = 2 * c.idle_count;
			end
			frame_no++;
			drive_cmd(c, 1'b0, NO_PINS);
			item_cnt++;
			for (int unsigned k = 0; k < len; k++) begin
				if ($urandom_range(0, 15) == 0)
					drive_cmd(rand_cmd(twdf_pkg::kind_t'($urandom_range(1, 3))), 1'b0,
						NO_PINS);
				drive_tick();
				item_cnt++;
			end
		end

		cmd_if.valid <= 1'b0;
		while (pins_q.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d send, %0d read and %0d idle frames; %0d results checked",
			send_frames, read_frames, idle_frames, checked_cnt);
		$display("%0d mismatches, %0d results still outstanding", mism_cnt, pins_q.size());
		if (mism_cnt == 0 && pins_q.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end
endmodule

// ----- two_wire_debug_frame_engine.f -----
+incdir+sv
sv/twdf_pkg.sv
sv/twdf_ifs.sv
sv/twdf_core.sv
sv/two_wire_debug_frame_engine.sv
tb/two_wire_debug_frame_engine_tb.sv
